// ===== rtl/core/acp_pkg.sv =====
// Shared types, character codes and result format of the ASCII flash command parser.
package acp_pkg;

  localparam int unsigned MaxPayloadDefault = 1024;

  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharW     = 8'h77;
  localparam logic [7:0] CharR     = 8'h72;
  localparam logic [7:0] CharA     = 8'h61;

  localparam logic [7:0] FieldsWrite = 8'd5;
  localparam logic [7:0] FieldsLread = 8'd4;
  localparam logic [7:0] FieldsOther = 8'd3;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_LREAD = 2'd1,
    CMD_PREAD = 2'd2
  } cmd_e;

  typedef enum logic {
    KIND_DATA = 1'b0,
    KIND_CMD  = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    cmd_e        command;
    logic [15:0] sector;
    logic [15:0] byte_offset;
    logic [15:0] length;
    logic [31:0] address;
    logic [7:0]  data_byte;
    logic [9:0]  data_index;
    logic [10:0] payload_count;
  } result_t;

endpackage

// ===== rtl/core/ascii_flash_command_parser_top.sv =====
// Top level of the ASCII flash command parser: input register, parser, result register.
// Words pass the input register and the parser; results go to the result register.
// Throughput: one word per cycle unless stalled; each parser state update is one step.
// A word advances out of the input register whenever the result register is empty
// or being read, so a stalled consumer holds the input side after one word.
// Reset (rst_ni low, asynchronous) clears both valid flags and all parser state.
module ascii_flash_command_parser_top #(
  parameter int unsigned MaxPayload = acp_pkg::MaxPayloadDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [1:0]  command_o,
  output logic [15:0] sector_o,
  output logic [15:0] byte_offset_o,
  output logic [15:0] length_o,
  output logic [31:0] address_o,
  output logic [7:0]  data_byte_o,
  output logic [9:0]  data_index_o,
  output logic [10:0] payload_count_o
);
  import acp_pkg::*;

  logic       item_valid;
  logic [7:0] item_byte;
  logic       out_free;
  logic       advance;
  logic       fire;
  logic       res_valid;
  result_t    res_next;
  result_t    res_out;

  // The held word moves on whenever the result register can take a result.
  assign advance = out_free;
  assign fire    = item_valid && advance;

  acp_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .rx_byte_i    (rx_byte_i),
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_byte_o  (item_byte)
  );

  // Parser state is only updated when a word is actually consumed.
  acp_parse #(
    .MaxPayload (MaxPayload)
  ) u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .byte_i      (item_byte),
    .res_valid_o (res_valid),
    .res_o       (res_next)
  );

  acp_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire && res_valid),
    .res_i       (res_next),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_out)
  );

  assign kind_o          = res_out.kind;
  assign command_o       = res_out.command;
  assign sector_o        = res_out.sector;
  assign byte_offset_o   = res_out.byte_offset;
  assign length_o        = res_out.length;
  assign address_o       = res_out.address;
  assign data_byte_o     = res_out.data_byte;
  assign data_index_o    = res_out.data_index;
  assign payload_count_o = res_out.payload_count;

endmodule

// ===== rtl/core/acp_in_stage.sv =====
// Input register that holds one received word until the parser consumes it.
module acp_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  input  logic       advance_i,
  output logic       item_valid_o,
  output logic [7:0] item_byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q, byte_d;
  logic       take;

  assign in_ready_o = !valid_q || advance_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    byte_d  = byte_q;
    if (take) begin
      valid_d = 1'b1;
      byte_d  = rx_byte_i;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign item_valid_o = valid_q;
  assign item_byte_o  = byte_q;

endmodule

// ===== rtl/core/acp_parse.sv =====
// Parser state and the single-word update that decodes commands and payload.
module acp_parse #(
  parameter int unsigned MaxPayload = acp_pkg::MaxPayloadDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [7:0]       byte_i,
  output logic             res_valid_o,
  output acp_pkg::result_t res_o
);
  import acp_pkg::*;

  localparam int unsigned KeptW = $clog2(MaxPayload + 1);
  localparam logic [KeptW-1:0] MaxKept = KeptW'(MaxPayload);

  logic             have_q, have_d;
  logic [7:0]       letter_q, letter_d;
  logic [7:0]       fields_q, fields_d;
  logic [15:0]      sector_q, sector_d;
  logic [15:0]      offset_q, offset_d;
  logic [15:0]      length_q, length_d;
  logic [31:0]      address_q, address_d;
  logic [KeptW-1:0] kept_q, kept_d;

  logic [15:0] digit16;
  logic [31:0] digit32;
  logic        known;
  cmd_e        code;

  assign digit16 = {8'd0, byte_i} - {8'd0, CharZero};
  assign digit32 = {24'd0, byte_i} - {24'd0, CharZero};

  // Accumulate one decimal digit: acc*10 as two shifts and an add.
  function automatic logic [15:0] acc16(input logic [15:0] acc, input logic [15:0] dig);
    acc16 = (acc << 3) + (acc << 1) + dig;
  endfunction

  function automatic logic [31:0] acc32(input logic [31:0] acc, input logic [31:0] dig);
    acc32 = (acc << 3) + (acc << 1) + dig;
  endfunction

  always_comb begin
    have_d      = have_q;
    letter_d    = letter_q;
    fields_d    = fields_q;
    sector_d    = sector_q;
    offset_d    = offset_q;
    length_d    = length_q;
    address_d   = address_q;
    kept_d      = kept_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    known       = 1'b0;
    code        = CMD_WRITE;

    if (byte_i == CharSpace) begin
      fields_d = fields_q - 8'd1;
    end else if (!have_q) begin
      letter_d = byte_i;
      if (byte_i == CharW) begin
        fields_d = FieldsWrite;
      end else if (byte_i == CharR) begin
        fields_d = FieldsLread;
      end else begin
        fields_d = FieldsOther;
      end
      have_d = 1'b1;
    end else begin
      unique case (letter_q)
        CharW: begin
          if (fields_q == 8'd4) sector_d = acc16(sector_q, digit16);
          if (fields_q == 8'd3) offset_d = acc16(offset_q, digit16);
          if (fields_q == 8'd2) length_d = acc16(length_q, digit16);
          if (fields_q == 8'd1 && kept_q < MaxKept) begin
            res_valid_o      = 1'b1;
            res_o.kind       = KIND_DATA;
            res_o.data_byte  = byte_i;
            res_o.data_index = 10'(kept_q);
            kept_d           = kept_q + KeptW'(1);
          end
        end
        CharR: begin
          if (fields_q == 8'd3) sector_d = acc16(sector_q, digit16);
          if (fields_q == 8'd2) offset_d = acc16(offset_q, digit16);
          if (fields_q == 8'd1) length_d = acc16(length_q, digit16);
        end
        CharA: begin
          if (fields_q == 8'd2) address_d = acc32(address_q, digit32);
          if (fields_q == 8'd1) length_d  = acc16(length_q, digit16);
        end
        default: ;
      endcase
    end

    // Countdown at zero closes the command, even when spaces alone got it there.
    if (fields_d == 8'd0) begin
      unique case (letter_d)
        CharW:   begin known = 1'b1; code = CMD_WRITE; end
        CharR:   begin known = 1'b1; code = CMD_LREAD; end
        CharA:   begin known = 1'b1; code = CMD_PREAD; end
        default: begin known = 1'b0; code = CMD_WRITE; end
      endcase
      if (known) begin
        res_valid_o         = 1'b1;
        res_o               = '0;
        res_o.kind          = KIND_CMD;
        res_o.command       = code;
        res_o.sector        = sector_d;
        res_o.byte_offset   = offset_d;
        res_o.length        = length_d;
        res_o.address       = address_d;
        res_o.payload_count = 11'(kept_d);
      end
      sector_d  = '0;
      offset_d  = '0;
      length_d  = '0;
      address_d = '0;
      kept_d    = '0;
      have_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q    <= 1'b0;
      letter_q  <= '0;
      fields_q  <= '0;
      sector_q  <= '0;
      offset_q  <= '0;
      length_q  <= '0;
      address_q <= '0;
      kept_q    <= '0;
    end else if (fire_i) begin
      have_q    <= have_d;
      letter_q  <= letter_d;
      fields_q  <= fields_d;
      sector_q  <= sector_d;
      offset_q  <= offset_d;
      length_q  <= length_d;
      address_q <= address_d;
      kept_q    <= kept_d;
    end
  end

endmodule

// ===== rtl/core/acp_out_stage.sv =====
// Result register that holds one result word until the consumer takes it.
module acp_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  acp_pkg::result_t res_i,
  output logic             free_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output acp_pkg::result_t res_o
);
  import acp_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q, res_d;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (load_i) begin
      valid_d = 1'b1;
      res_d   = res_i;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ===== test/tb_ascii_flash_command_parser_top.sv =====
// Self-checking testbench for the ASCII flash command parser top level.
module tb_ascii_flash_command_parser_top;
  import acp_pkg::*;

  // The run is bounded by a cycle count far above the slowest legal run. That run is
  // roughly 2700 words, each with the longest sender gap and the longest receiver stall.
  localparam int unsigned CycleLimit  = 600000;
  localparam int unsigned RandomWords = 1000;

  // A row of the directed table: the byte to send and, where it is obvious by hand,
  // the result it must produce. Rows without a typed result go through the predictor.
  typedef struct packed {
    logic [7:0] rx;
    logic       typed;
    result_t    want;
  } stim_row_t;

  localparam result_t NoResult = '0;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [7:0]  rx_byte_i   = 8'h00;
  logic        out_ready_i = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic        kind_o;
  logic [1:0]  command_o;
  logic [15:0] sector_o;
  logic [15:0] byte_offset_o;
  logic [15:0] length_o;
  logic [31:0] address_o;
  logic [7:0]  data_byte_o;
  logic [9:0]  data_index_o;
  logic [10:0] payload_count_o;

  // Parser state as the predictor sees it; all of it starts cleared, as after reset.
  logic        cmd_open     = 1'b0;
  logic [7:0]  cmd_letter   = 8'h00;
  logic [7:0]  spaces_left  = 8'h00;
  logic [15:0] sector_sum   = 16'h0000;
  logic [15:0] offset_sum   = 16'h0000;
  logic [15:0] length_sum   = 16'h0000;
  logic [31:0] address_sum  = 32'h0000_0000;
  logic [10:0] payload_seen = 11'd0;
  logic        word_effective;

  result_t       expected_results[$];
  int unsigned   mismatches   = 0;
  int unsigned   useful_words = 0;
  int unsigned   cycle_count  = 0;
  int unsigned   send_gap     = 0;
  int unsigned   recv_wait    = 3;
  logic          send_quiet   = 1'b0;
  logic          recv_quiet   = 1'b0;
  logic [7:0]    known_letters [3] = '{CharW, CharR, CharA};

  // Directed words. They walk through a physical read whose length comes from a zero
  // byte, a countdown underflow on a space with nothing open, a write with an all-ones
  // payload byte, a logical read with empty fields and a command with an unknown letter.
  stim_row_t directed_rows [25] = '{
    {CharA,     1'b0, NoResult},
    {CharSpace, 1'b0, NoResult},
    {8'h39,     1'b0, NoResult},
    {CharSpace, 1'b0, NoResult},
    {8'h00,     1'b0, NoResult},
    {CharSpace, 1'b1, {KIND_CMD, CMD_PREAD, 16'h0000, 16'h0000, 16'hFFD0, 32'd9,
                       8'h00, 10'd0, 11'd0}},
    {CharSpace, 1'b0, NoResult},
    {CharW,     1'b0, NoResult},
    {CharSpace, 1'b0, NoResult},
    {8'h00,     1'b0, NoResult},
    {CharSpace, 1'b0, NoResult},
    {CharSpace, 1'b0, NoResult},
    {8'h32,     1'b0, NoResult},
    {CharSpace, 1'b0, NoResult},
    {8'hFF,     1'b1, {KIND_DATA, CMD_WRITE, 16'h0000, 16'h0000, 16'h0000, 32'd0,
                       8'hFF, 10'd0, 11'd0}},
    {CharSpace, 1'b1, {KIND_CMD, CMD_WRITE, 16'hFFD0, 16'h0000, 16'h0002, 32'd0,
                       8'h00, 10'd0, 11'd1}},
    {CharR,     1'b0, NoResult},
    {CharSpace, 1'b0, NoResult},
    {CharSpace, 1'b0, NoResult},
    {CharSpace, 1'b0, NoResult},
    {CharSpace, 1'b1, {KIND_CMD, CMD_LREAD, 16'h0000, 16'h0000, 16'h0000, 32'd0,
                       8'h00, 10'd0, 11'd0}},
    {8'h78,     1'b0, NoResult},
    {CharSpace, 1'b0, NoResult},
    {CharSpace, 1'b0, NoResult},
    {CharSpace, 1'b0, NoResult}
  };

  ascii_flash_command_parser_top #(
    .MaxPayload(MaxPayloadDefault)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .command_o      (command_o),
    .sector_o       (sector_o),
    .byte_offset_o  (byte_offset_o),
    .length_o       (length_o),
    .address_o      (address_o),
    .data_byte_o    (data_byte_o),
    .data_index_o   (data_index_o),
    .payload_count_o(payload_count_o)
  );

  always #5 clk_i = ~clk_i;

  // Advances the predicted parser by one received byte. It returns whether the byte
  // produces a result and sets word_effective low when the parser simply drops it.
  function automatic logic parse_word(input logic [7:0] b, output result_t res);
    logic fires;
    res = '0;
    fires = 1'b0;
    word_effective = 1'b1;
    if (b == CharSpace) begin
      // A space with the countdown at zero wraps it around to 255.
      spaces_left = spaces_left - 8'd1;
    end else if (!cmd_open) begin
      cmd_letter = b;
      if (b == CharW) begin
        spaces_left = FieldsWrite;
      end else if (b == CharR) begin
        spaces_left = FieldsLread;
      end else begin
        spaces_left = FieldsOther;
      end
      cmd_open = 1'b1;
    end else if (cmd_letter == CharW) begin
      case (spaces_left)
        8'd4: sector_sum = sector_sum * 16'd10 + 16'(b) - 16'(CharZero);
        8'd3: offset_sum = offset_sum * 16'd10 + 16'(b) - 16'(CharZero);
        8'd2: length_sum = length_sum * 16'd10 + 16'(b) - 16'(CharZero);
        8'd1: begin
          // Payload bytes beyond the buffer size are dropped without a word out.
          if (payload_seen < 11'(MaxPayloadDefault)) begin
            res.kind       = KIND_DATA;
            res.data_byte  = b;
            res.data_index = payload_seen[9:0];
            payload_seen   = payload_seen + 11'd1;
            fires          = 1'b1;
          end else begin
            word_effective = 1'b0;
          end
        end
        default: word_effective = 1'b0;
      endcase
    end else if (cmd_letter == CharR) begin
      case (spaces_left)
        8'd3: sector_sum = sector_sum * 16'd10 + 16'(b) - 16'(CharZero);
        8'd2: offset_sum = offset_sum * 16'd10 + 16'(b) - 16'(CharZero);
        8'd1: length_sum = length_sum * 16'd10 + 16'(b) - 16'(CharZero);
        default: word_effective = 1'b0;
      endcase
    end else if (cmd_letter == CharA) begin
      case (spaces_left)
        8'd2: address_sum = address_sum * 32'd10 + 32'(b) - 32'(CharZero);
        8'd1: length_sum = length_sum * 16'd10 + 16'(b) - 16'(CharZero);
        default: word_effective = 1'b0;
      endcase
    end else begin
      word_effective = 1'b0;
    end

    // Completion also fires when spaces alone run the countdown down with nothing
    // open; the last letter is then decoded with cleared sums.
    if (spaces_left == 8'd0) begin
      if (cmd_letter == CharW || cmd_letter == CharR || cmd_letter == CharA) begin
        res      = '0;
        res.kind = KIND_CMD;
        if (cmd_letter == CharW) begin
          res.command = CMD_WRITE;
        end else if (cmd_letter == CharR) begin
          res.command = CMD_LREAD;
        end else begin
          res.command = CMD_PREAD;
        end
        res.sector        = sector_sum;
        res.byte_offset   = offset_sum;
        res.length        = length_sum;
        res.address       = address_sum;
        res.payload_count = payload_seen;
        fires             = 1'b1;
      end
      sector_sum   = '0;
      offset_sum   = '0;
      length_sum   = '0;
      address_sum  = '0;
      payload_seen = '0;
      cmd_open     = 1'b0;
    end
    return fires;
  endfunction

  function automatic logic [7:0] random_non_space();
    logic [7:0] b;
    b = 8'($urandom_range(0, 254));
    if (b >= CharSpace) b = b + 8'd1;
    return b;
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Sends one word and records what it must produce. It is always entered at a rising
  // edge, and valid is lowered only when a gap follows, so back-to-back words keep
  // valid high without a second assignment in the same step.
  task automatic send_word(input logic [7:0] b, input logic typed = 1'b0,
                           input result_t want = '0);
    result_t predicted;
    logic    fires;
    if (send_gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (send_gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    fires = parse_word(b, predicted);
    if (typed) begin
      expected_results.push_back(want);
    end else if (fires) begin
      expected_results.push_back(predicted);
    end
    if (word_effective) useful_words++;
    send_gap = send_quiet ? 0 : $urandom_range(0, 14);
    if ($urandom_range(0, 63) == 0) send_quiet = !send_quiet;
  endtask

  // Sends a command letter and up to stop_after of its spaces, filling each field
  // with decimal digits, an occasional stray byte, and payload bytes for a write.
  task automatic send_command(input logic [7:0] letter, input int unsigned stop_after,
                              input int unsigned payload_words);
    int unsigned total;
    int unsigned remaining;
    int unsigned digits;
    total = (letter == CharW) ? 5 : (letter == CharR) ? 4 : 3;
    send_word(letter);
    // A byte before the first space lands on a countdown that selects no field.
    if ($urandom_range(0, 7) == 0) send_word(random_non_space());
    for (int unsigned k = 1; k <= total && k <= stop_after; k++) begin
      send_word(CharSpace);
      remaining = total - k;
      if (remaining == 0) begin
      end else if (letter == CharW && remaining == 1) begin
        repeat (payload_words) send_word(random_non_space());
      end else begin
        digits = (letter == CharA && remaining == 2) ? $urandom_range(0, 11)
                                                      : $urandom_range(0, 6);
        repeat (digits) begin
          if ($urandom_range(0, 15) == 0) begin
            send_word(random_non_space());
          end else begin
            send_word(CharZero + 8'($urandom_range(0, 9)));
          end
        end
      end
    end
  endtask

  // Spaces finish whatever command is still open so the next one starts clean.
  task automatic close_open_command();
    while (cmd_open) send_word(CharSpace);
  endtask

  // Holds the sender off until every predicted word has come out.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Receiver: stalls a random number of cycles after each word, with stretches of
  // no stalls, and checks every accepted word against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result word with nothing expected: kind %0d, command %0d",
                 kind_o, command_o);
          mismatches++;
        end else begin
          compare_field("kind", expected_results[0].kind, kind_o);
          compare_field("command", expected_results[0].command, command_o);
          compare_field("sector", expected_results[0].sector, sector_o);
          compare_field("byte_offset", expected_results[0].byte_offset, byte_offset_o);
          compare_field("length", expected_results[0].length, length_o);
          compare_field("address", expected_results[0].address, address_o);
          compare_field("data_byte", expected_results[0].data_byte, data_byte_o);
          compare_field("data_index", expected_results[0].data_index, data_index_o);
          compare_field("payload_count", expected_results[0].payload_count,
                        payload_count_o);
          void'(expected_results.pop_front());
        end
        recv_wait = recv_quiet ? 0 : $urandom_range(0, 14);
        if ($urandom_range(0, 63) == 0) recv_quiet = !recv_quiet;
        if (recv_wait != 0) out_ready_i <= 1'b0;
      end else if (!out_ready_i) begin
        if (recv_wait != 0) recv_wait--;
        if (recv_wait == 0) out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic [7:0] letter;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      send_word(directed_rows[r].rx, directed_rows[r].typed, directed_rows[r].want);
    end
    drain_results();

    // A write that overruns the payload buffer: every data index appears once, the
    // surplus bytes are dropped, and the command reports a full buffer.
    close_open_command();
    send_command(CharW, 5, MaxPayloadDefault + 6);
    // With nothing open, 256 spaces wrap the countdown back to zero and complete
    // the last letter again with cleared fields.
    repeat (256) send_word(CharSpace);
    drain_results();

    // Random part: mostly well-formed commands with random content, mixed with
    // truncated commands, unknown letters and raw noise bytes.
    useful_words = 0;
    while (useful_words < RandomWords) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          repeat ($urandom_range(1, 8)) begin
            send_word(($urandom_range(0, 3) == 0) ? CharSpace : 8'($urandom_range(0, 255)));
          end
        end
        2: begin
          send_command(known_letters[$urandom_range(0, 2)], $urandom_range(0, 4),
                       $urandom_range(0, 12));
        end
        3, 4, 5: begin
          close_open_command();
          send_command(CharW, 5, $urandom_range(0, 12));
        end
        6, 7: begin
          close_open_command();
          send_command(CharR, 4, 0);
        end
        8: begin
          close_open_command();
          send_command(CharA, 3, 0);
        end
        default: begin
          close_open_command();
          do letter = random_non_space();
          while (letter == CharW || letter == CharR || letter == CharA);
          send_command(letter, 3, 0);
        end
      endcase
      if (useful_words >= RandomWords / 2 && useful_words < RandomWords / 2 + 40 &&
          expected_results.size() != 0) begin
        drain_results();
      end
    end

    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    // The extra wait afterwards catches any stray word.
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== ascii_flash_command_parser_top.f =====
rtl/core/acp_pkg.sv
rtl/core/acp_in_stage.sv
rtl/core/acp_parse.sv
rtl/core/acp_out_stage.sv
rtl/core/ascii_flash_command_parser_top.sv
test/tb_ascii_flash_command_parser_top.sv
